FILE: hdl/risc_core_shared_memory_core_assert.svh
// Assertion macros shared by the shared-memory core RTL.
// Needs nothing else; files that check their own logic include it.
`ifndef RISC_CORE_SHARED_MEMORY_CORE_ASSERT_SVH
`define RISC_CORE_SHARED_MEMORY_CORE_ASSERT_SVH

// same-cycle implication under synchronous reset
`define RCSM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("core check failed: same-cycle implication");

// next-cycle implication under synchronous reset
`define RCSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("core check failed: next-cycle implication");

`endif

FILE: hdl/rcsm_pkg.sv
// Shared types and constants for the shared-memory core.
// No dependencies; every other file but the assertion header refers to it by scoped names.
package rcsm_pkg;

   localparam int XLEN         = 32;
   localparam int ADDR_FIELD_W = 11;
   localparam int PLEN_W       = 12;
   localparam int REG_COUNT    = 32;
   localparam int REG_IDX_W    = 5;

   // instruction layout
   localparam int OPC_LSB = 28;
   localparam int OPC_W   = 4;
   localparam int RS_LSB  = 23;
   localparam int RT_LSB  = 18;
   localparam int RD_LSB  = 13;
   localparam int SHAMT_W = 13;
   localparam int IMM_W   = 18;
   localparam int JADDR_W = 28;
   localparam int IMM_SPAN = 131072;

   // serial address wrap: digit bits per step and step count
   localparam int MOD_DIGIT_BITS = 4;
   localparam int MOD_STEPS      = XLEN / MOD_DIGIT_BITS;
   localparam int MOD_CNT_W      = $clog2(MOD_STEPS);

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_PROGRAM_LENGTH = 1'b0;

   typedef enum logic [1:0] {
      CMD_MEM_WRITE = 2'd0,
      CMD_EXECUTE   = 2'd1,
      CMD_REG_READ  = 2'd2,
      CMD_MEM_READ  = 2'd3
   } cmd_code_type;

   typedef enum logic [OPC_W-1:0] {
      OP_ADD  = 4'd0,
      OP_SUB  = 4'd1,
      OP_MULI = 4'd2,
      OP_ADDI = 4'd3,
      OP_BNE  = 4'd4,
      OP_ANDI = 4'd5,
      OP_ORI  = 4'd6,
      OP_J    = 4'd7,
      OP_SLL  = 4'd8,
      OP_SRL  = 4'd9,
      OP_LW   = 4'd10,
      OP_SW   = 4'd11
   } opcode_type;

   typedef struct packed {
      logic capture;
      logic fetch;
      logic decode;
      logic rf_read;
      logic exec;
      logic mod_start;
      logic mem_read;
      logic mem_write;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_code_type cmd_code;
      logic         halted;
      logic         needs_mod;
      logic         need_load;
      logic         need_store;
      logic         mod_done;
   } ctrl_sts_type;

endpackage

FILE: hdl/rcsm_mod_unit.sv
// Address wrap unit: reduces a 32-bit value modulo MEM_WORDS.
// Power-of-two sizes mask the low bits; others reduce 4 bits per cycle.
module rcsm_mod_unit #(
   parameter int MEM_WORDS = 2048
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rcsm_pkg::XLEN-1:0]     value,
   output logic                          done,
   output logic [$clog2(MEM_WORDS)-1:0]  result
);

   localparam int AW = $clog2(MEM_WORDS);
   localparam bit POW2 = ((MEM_WORDS & (MEM_WORDS - 1)) == 0);

   logic          done_ff, done_in;
   logic [AW-1:0] result_ff, result_in;

   generate
      if (POW2) begin : g_mask
         always_comb begin
            done_in   = start;
            result_in = start ? value[AW-1:0] : result_ff;
         end
      end else begin : g_serial
         localparam logic [AW:0] MOD_M = (AW + 1)'(MEM_WORDS);

         logic [rcsm_pkg::XLEN-1:0]      shift_ff, shift_in;
         logic [rcsm_pkg::MOD_CNT_W-1:0] count_ff, count_in;
         logic                           busy_ff, busy_in;
         logic [AW:0]                    rem;

         always_comb begin
            // shift in one digit, MSB first, keeping the remainder below MOD_M
            rem = {1'b0, result_ff};
            for (int i = 0; i < rcsm_pkg::MOD_DIGIT_BITS; i++) begin
               rem = {rem[AW-1:0], shift_ff[rcsm_pkg::XLEN-1-i]};
               if (rem >= MOD_M) begin
                  rem = rem - MOD_M;
               end
            end

            shift_in  = shift_ff;
            count_in  = count_ff;
            busy_in   = busy_ff;
            result_in = result_ff;
            done_in   = 1'b0;
            if (start) begin
               shift_in  = value;
               count_in  = rcsm_pkg::MOD_CNT_W'(rcsm_pkg::MOD_STEPS - 1);
               busy_in   = 1'b1;
               result_in = '0;
            end else if (busy_ff) begin
               shift_in  = shift_ff << rcsm_pkg::MOD_DIGIT_BITS;
               result_in = rem[AW-1:0];
               count_in  = count_ff - 1'b1;
               if (count_ff == '0) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               busy_ff <= 1'b0;
            end else begin
               busy_ff <= busy_in;
            end
            shift_ff <= shift_in;
            count_ff <= count_in;
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

FILE: hdl/rcsm_datapath.sv
// Datapath of the shared-memory core: shared memory, register file, ALU, pc.
// Uses rcsm_pkg, rcsm_mod_unit and the assertion macro header.
`include "risc_core_shared_memory_core_assert.svh"

module rcsm_datapath #(
   parameter int MEM_WORDS = 2048
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rcsm_pkg::ctrl_cmd_type               cmd,
   output rcsm_pkg::ctrl_sts_type               sts,
   input  logic [1:0]                           req_command,
   input  logic [rcsm_pkg::ADDR_FIELD_W-1:0]    req_word_address,
   input  logic [rcsm_pkg::XLEN-1:0]            req_write_data,
   input  logic [rcsm_pkg::PLEN_W-1:0]          program_length,
   output logic [rcsm_pkg::ADDR_FIELD_W-1:0]    rsp_next_pc,
   output logic                                 rsp_halted,
   output logic                                 rsp_reg_written,
   output logic [rcsm_pkg::REG_IDX_W-1:0]       rsp_dest_reg,
   output logic [rcsm_pkg::XLEN-1:0]            rsp_result_value,
   output logic                                 rsp_mem_stored,
   output logic [rcsm_pkg::ADDR_FIELD_W-1:0]    rsp_mem_address,
   output logic                                 rsp_branch_taken
);

   localparam int AW = $clog2(MEM_WORDS);
   localparam int XW = rcsm_pkg::XLEN;
   localparam int RW = rcsm_pkg::REG_IDX_W;
   localparam int FW = rcsm_pkg::ADDR_FIELD_W;
   localparam int BNE_WRAPS = (rcsm_pkg::IMM_SPAN + MEM_WORDS - 1) / MEM_WORDS;
   localparam logic [XW-1:0] BNE_BIAS = XW'(BNE_WRAPS * MEM_WORDS);
   localparam logic [AW-1:0] PC_LAST  = AW'(MEM_WORDS - 1);

   // captured request word
   rcsm_pkg::cmd_code_type cmd_code_ff;
   logic [FW-1:0]          waddr_ff;
   logic [XW-1:0]          wdata_ff;

   logic [AW-1:0] pc_ff, pc_in;

   logic [XW-1:0] main_mem [MEM_WORDS];
   logic [XW-1:0] mem_rdata_ff;
   logic [AW-1:0] mem_raddr;
   logic [XW-1:0] mem_wdata;

   logic [XW-1:0]                      reg_mem [rcsm_pkg::REG_COUNT];
   logic [rcsm_pkg::REG_COUNT-1:0]     rf_valid_ff;
   logic [XW-1:0]                      rf_a_ff, rf_b_ff;
   logic                               rf_a_ok_ff, rf_b_ok_ff;
   logic [RW-1:0]                      rf_ra, rf_rb, rf_waddr;
   logic                               rf_we;

   logic [XW-1:0] instr_ff;
   logic [XW-1:0] val_ff, alu_val;
   logic [RW-1:0] dst_ff, alu_dst;
   logic          wr_ff, alu_wr;
   logic          taken_ff, alu_taken;

   logic [rcsm_pkg::OPC_W-1:0]   opc;
   logic [rcsm_pkg::SHAMT_W-1:0] shamt;
   logic [XW-1:0]                imm_sext;
   logic [XW-1:0]                op_a, op_b;
   logic [XW-1:0]                mul_lo;
   logic [XW-1:0]                ea_sum, bne_target;
   logic                         big_shift, is_lw, is_sw;
   logic                         halt_now, exec_item;
   logic [AW-1:0]                pc_seq, npc;
   logic [XW-1:0]                finish_value;

   logic [XW-1:0] mod_value;
   logic [AW-1:0] mod_result;
   logic          mod_done;

   logic [FW-1:0] rsp_next_pc_ff, rsp_next_pc_in;
   logic          rsp_halted_ff, rsp_halted_in;
   logic          rsp_reg_written_ff, rsp_reg_written_in;
   logic [RW-1:0] rsp_dest_reg_ff, rsp_dest_reg_in;
   logic [XW-1:0] rsp_result_value_ff, rsp_result_value_in;
   logic          rsp_mem_stored_ff, rsp_mem_stored_in;
   logic [FW-1:0] rsp_mem_address_ff, rsp_mem_address_in;
   logic          rsp_branch_taken_ff, rsp_branch_taken_in;

   // decode fields of the held instruction
   assign opc       = instr_ff[rcsm_pkg::OPC_LSB +: rcsm_pkg::OPC_W];
   assign shamt     = instr_ff[rcsm_pkg::SHAMT_W-1:0];
   assign big_shift = |shamt[rcsm_pkg::SHAMT_W-1:5];
   assign imm_sext  = {{(XW - rcsm_pkg::IMM_W){instr_ff[rcsm_pkg::IMM_W-1]}},
                       instr_ff[rcsm_pkg::IMM_W-1:0]};
   assign is_lw     = (opc == rcsm_pkg::OP_LW);
   assign is_sw     = (opc == rcsm_pkg::OP_SW);

   // never-written registers read as zero
   assign op_a = rf_a_ok_ff ? rf_a_ff : '0;
   assign op_b = rf_b_ok_ff ? rf_b_ff : '0;

   assign mul_lo     = op_a * imm_sext;
   assign ea_sum     = op_a + imm_sext;
   assign bne_target = XW'(pc_ff) + XW'(1) + imm_sext + BNE_BIAS;

   always_comb begin
      alu_val   = '0;
      alu_dst   = '0;
      alu_wr    = 1'b0;
      alu_taken = 1'b0;
      case (opc)
         rcsm_pkg::OP_ADD: begin
            alu_val = op_a + op_b;
            alu_dst = instr_ff[rcsm_pkg::RD_LSB +: RW];
            alu_wr  = 1'b1;
         end
         rcsm_pkg::OP_SUB: begin
            alu_val = op_a - op_b;
            alu_dst = instr_ff[rcsm_pkg::RD_LSB +: RW];
            alu_wr  = 1'b1;
         end
         rcsm_pkg::OP_MULI: begin
            alu_val = mul_lo;
            alu_dst = instr_ff[rcsm_pkg::RT_LSB +: RW];
            alu_wr  = 1'b1;
         end
         rcsm_pkg::OP_ADDI: begin
            alu_val = ea_sum;
            alu_dst = instr_ff[rcsm_pkg::RT_LSB +: RW];
            alu_wr  = 1'b1;
         end
         rcsm_pkg::OP_BNE: begin
            alu_taken = (op_a != op_b);
         end
         rcsm_pkg::OP_ANDI: begin
            alu_val = op_a & imm_sext;
            alu_dst = instr_ff[rcsm_pkg::RT_LSB +: RW];
            alu_wr  = 1'b1;
         end
         rcsm_pkg::OP_ORI: begin
            alu_val = op_a | imm_sext;
            alu_dst = instr_ff[rcsm_pkg::RT_LSB +: RW];
            alu_wr  = 1'b1;
         end
         rcsm_pkg::OP_J: begin
            alu_taken = 1'b1;
         end
         rcsm_pkg::OP_SLL: begin
            alu_val = big_shift ? '0 : (op_a << shamt[4:0]);
            alu_dst = instr_ff[rcsm_pkg::RT_LSB +: RW];
            alu_wr  = 1'b1;
         end
         rcsm_pkg::OP_SRL: begin
            alu_val = big_shift ? '0 : (op_a >> shamt[4:0]);
            alu_dst = instr_ff[rcsm_pkg::RT_LSB +: RW];
            alu_wr  = 1'b1;
         end
         rcsm_pkg::OP_LW: begin
            alu_dst = instr_ff[rcsm_pkg::RT_LSB +: RW];
            alu_wr  = 1'b1;
         end
         rcsm_pkg::OP_SW: begin
            alu_val = op_b;
         end
         default: begin
         end
      endcase
   end

   // wrap source: request address, jump field, branch target or load/store address
   always_comb begin
      if (cmd_code_ff == rcsm_pkg::CMD_MEM_WRITE || cmd_code_ff == rcsm_pkg::CMD_MEM_READ) begin
         mod_value = XW'(waddr_ff);
      end else if (opc == rcsm_pkg::OP_J) begin
         mod_value = XW'(instr_ff[rcsm_pkg::JADDR_W-1:0]);
      end else if (opc == rcsm_pkg::OP_BNE) begin
         mod_value = bne_target;
      end else begin
         mod_value = ea_sum;
      end
   end

   rcsm_mod_unit #(
      .MEM_WORDS (MEM_WORDS)
   ) u_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mod_start),
      .value  (mod_value),
      .done   (mod_done),
      .result (mod_result)
   );

   assign halt_now  = (XW'(pc_ff) >= XW'(program_length));
   assign exec_item = (cmd_code_ff == rcsm_pkg::CMD_EXECUTE) && !halt_now;
   assign pc_seq    = (pc_ff == PC_LAST) ? '0 : pc_ff + AW'(1);
   assign npc       = taken_ff ? mod_result : pc_seq;
   assign pc_in     = (cmd.finish && exec_item) ? npc : pc_ff;

   assign finish_value = is_lw ? mem_rdata_ff : val_ff;

   // shared memory: one port for fetch, load and store
   assign mem_raddr = cmd.fetch ? pc_ff : mod_result;
   assign mem_wdata = (cmd_code_ff == rcsm_pkg::CMD_MEM_WRITE) ? wdata_ff : op_b;

   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         main_mem[mod_result] <= mem_wdata;
      end
      if (cmd.fetch || cmd.mem_read) begin
         mem_rdata_ff <= main_mem[mem_raddr];
      end
   end

   // register file: two read ports, one write port
   assign rf_ra    = (cmd_code_ff == rcsm_pkg::CMD_REG_READ) ? waddr_ff[RW-1:0]
                                                              : mem_rdata_ff[rcsm_pkg::RS_LSB +: RW];
   assign rf_rb    = mem_rdata_ff[rcsm_pkg::RT_LSB +: RW];
   assign rf_waddr = dst_ff;
   assign rf_we    = cmd.finish && exec_item && wr_ff && (dst_ff != '0);

   always_ff @(posedge clock) begin
      if (rf_we) begin
         reg_mem[rf_waddr] <= finish_value;
      end
      if (cmd.rf_read) begin
         rf_a_ff    <= reg_mem[rf_ra];
         rf_b_ff    <= reg_mem[rf_rb];
         rf_a_ok_ff <= rf_valid_ff[rf_ra];
         rf_b_ok_ff <= rf_valid_ff[rf_rb];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_valid_ff <= '0;
         pc_ff       <= '0;
      end else begin
         if (rf_we) begin
            rf_valid_ff[rf_waddr] <= 1'b1;
         end
         pc_ff <= pc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_code_ff <= rcsm_pkg::cmd_code_type'(req_command);
         waddr_ff    <= req_word_address;
         wdata_ff    <= req_write_data;
      end
      if (cmd.decode) begin
         instr_ff <= mem_rdata_ff;
      end
      if (cmd.exec) begin
         val_ff   <= alu_val;
         dst_ff   <= alu_dst;
         wr_ff    <= alu_wr;
         taken_ff <= alu_taken;
      end
   end

   // result word
   always_comb begin
      rsp_next_pc_in      = FW'(pc_ff);
      rsp_halted_in       = 1'b0;
      rsp_reg_written_in  = 1'b0;
      rsp_dest_reg_in     = '0;
      rsp_result_value_in = '0;
      rsp_mem_stored_in   = 1'b0;
      rsp_mem_address_in  = '0;
      rsp_branch_taken_in = 1'b0;
      case (cmd_code_ff)
         rcsm_pkg::CMD_MEM_WRITE: begin
            rsp_result_value_in = wdata_ff;
            rsp_mem_address_in  = FW'(mod_result);
         end
         rcsm_pkg::CMD_MEM_READ: begin
            rsp_result_value_in = mem_rdata_ff;
            rsp_mem_address_in  = FW'(mod_result);
         end
         rcsm_pkg::CMD_REG_READ: begin
            rsp_result_value_in = op_a;
         end
         rcsm_pkg::CMD_EXECUTE: begin
            if (halt_now) begin
               rsp_halted_in = 1'b1;
            end else begin
               rsp_next_pc_in      = FW'(npc);
               rsp_reg_written_in  = wr_ff && (dst_ff != '0);
               rsp_dest_reg_in     = dst_ff;
               rsp_result_value_in = finish_value;
               rsp_mem_stored_in   = is_sw;
               rsp_mem_address_in  = (is_lw || is_sw) ? FW'(mod_result) : '0;
               rsp_branch_taken_in = taken_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_next_pc_ff      <= rsp_next_pc_in;
         rsp_halted_ff       <= rsp_halted_in;
         rsp_reg_written_ff  <= rsp_reg_written_in;
         rsp_dest_reg_ff     <= rsp_dest_reg_in;
         rsp_result_value_ff <= rsp_result_value_in;
         rsp_mem_stored_ff   <= rsp_mem_stored_in;
         rsp_mem_address_ff  <= rsp_mem_address_in;
         rsp_branch_taken_ff <= rsp_branch_taken_in;
      end
   end

   assign rsp_next_pc      = rsp_next_pc_ff;
   assign rsp_halted       = rsp_halted_ff;
   assign rsp_reg_written  = rsp_reg_written_ff;
   assign rsp_dest_reg     = rsp_dest_reg_ff;
   assign rsp_result_value = rsp_result_value_ff;
   assign rsp_mem_stored   = rsp_mem_stored_ff;
   assign rsp_mem_address  = rsp_mem_address_ff;
   assign rsp_branch_taken = rsp_branch_taken_ff;

   assign sts.cmd_code   = cmd_code_ff;
   assign sts.halted     = halt_now;
   assign sts.needs_mod  = alu_taken || is_lw || is_sw;
   assign sts.need_load  = (cmd_code_ff == rcsm_pkg::CMD_MEM_READ) ||
                           ((cmd_code_ff == rcsm_pkg::CMD_EXECUTE) && is_lw);
   assign sts.need_store = (cmd_code_ff == rcsm_pkg::CMD_MEM_WRITE) ||
                           ((cmd_code_ff == rcsm_pkg::CMD_EXECUTE) && is_sw);
   assign sts.mod_done   = mod_done;

   `RCSM_ASSERT_NEXT(a_r0_reads_zero, clock, reset, cmd.rf_read && (rf_ra == '0), op_a == '0)
   `RCSM_ASSERT_IMPLY(a_pc_in_range, clock, reset, 1'b1, XW'(pc_ff) < XW'(MEM_WORDS))
   `RCSM_ASSERT_IMPLY(a_wrap_in_range, clock, reset, mod_done, XW'(mod_result) < XW'(MEM_WORDS))

endmodule

FILE: hdl/rcsm_ctrl.sv
// Sequencer of the shared-memory core: walks each command through its phases.
// Uses rcsm_pkg command and status structs.
module rcsm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rcsm_pkg::ctrl_cmd_type cmd,
   input  rcsm_pkg::ctrl_sts_type sts
);

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_DISPATCH = 6'b000010,
      S_DECODE   = 6'b000100,
      S_EXEC     = 6'b001000,
      S_REDUCE   = 6'b010000,
      S_FINISH   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (sts.cmd_code)
               rcsm_pkg::CMD_MEM_WRITE: begin
                  cmd.mod_start = 1'b1;
                  state_in      = S_REDUCE;
               end
               rcsm_pkg::CMD_MEM_READ: begin
                  cmd.mod_start = 1'b1;
                  state_in      = S_REDUCE;
               end
               rcsm_pkg::CMD_REG_READ: begin
                  cmd.rf_read = 1'b1;
                  state_in    = S_FINISH;
               end
               rcsm_pkg::CMD_EXECUTE: begin
                  if (sts.halted) begin
                     state_in = S_FINISH;
                  end else begin
                     cmd.fetch = 1'b1;
                     state_in  = S_DECODE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_DECODE: begin
            cmd.decode  = 1'b1;
            cmd.rf_read = 1'b1;
            state_in    = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.needs_mod) begin
               cmd.mod_start = 1'b1;
               state_in      = S_REDUCE;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_REDUCE: begin
            // wrapped address is ready: do the data access
            if (sts.mod_done) begin
               cmd.mem_read  = sts.need_load;
               cmd.mem_write = sts.need_store;
               state_in      = S_FINISH;
            end
         end
         S_FINISH: begin
            // hold until the output register can take the word
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hdl/risc_core_shared_memory_core.sv
// Channel   Direction  Handshake            Carries
// req       in         req_valid/req_stall  command, word_address, write_data
// rsp       out        rsp_valid/rsp_stall  pc, flags, dest, value, data address
// csr       in/out     psel/penable/pready  program_length at byte address 0
//
// Each command runs only the phases that it needs, in this order: fetch, register
// read, address wrap, data access; fetch and data access share the single memory port.
// MEM_WORDS sizes that are not a power of two wrap addresses 4 bits per cycle.
// Reset is synchronous: pc, register file and program_length clear; memory is
// undefined until written. A finished word waits in the output register while
// the next request is taken; a stalled result holds only its last phase.
module risc_core_shared_memory_core #(
   parameter int MEM_WORDS = 2048
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [1:0]                              req_command,
   input  logic [rcsm_pkg::ADDR_FIELD_W-1:0]       req_word_address,
   input  logic [rcsm_pkg::XLEN-1:0]               req_write_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [rcsm_pkg::ADDR_FIELD_W-1:0]       rsp_next_pc,
   output logic                                    rsp_halted,
   output logic                                    rsp_reg_written,
   output logic [rcsm_pkg::REG_IDX_W-1:0]          rsp_dest_reg,
   output logic [rcsm_pkg::XLEN-1:0]               rsp_result_value,
   output logic                                    rsp_mem_stored,
   output logic [rcsm_pkg::ADDR_FIELD_W-1:0]       rsp_mem_address,
   output logic                                    rsp_branch_taken,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [rcsm_pkg::CSR_ADDR_W-1:0]         paddr,
   input  logic [rcsm_pkg::CSR_DATA_W-1:0]         pwdata,
   output logic [rcsm_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                    pready
);

   rcsm_pkg::ctrl_cmd_type cmd;
   rcsm_pkg::ctrl_sts_type sts;

   logic [rcsm_pkg::PLEN_W-1:0] program_length_ff, program_length_in;
   logic                        csr_hit;
   logic                        csr_write;

   // register index is the address above the byte offset
   assign csr_hit   = (paddr[rcsm_pkg::CSR_ADDR_W-1] == rcsm_pkg::CSR_IDX_PROGRAM_LENGTH);
   assign csr_write = psel && penable && pwrite && pready && csr_hit;

   assign program_length_in = csr_write ? pwdata[rcsm_pkg::PLEN_W-1:0] : program_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         program_length_ff <= '0;
      end else begin
         program_length_ff <= program_length_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = csr_hit ? rcsm_pkg::CSR_DATA_W'(program_length_ff) : '0;

   rcsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   rcsm_datapath #(
      .MEM_WORDS (MEM_WORDS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_command      (req_command),
      .req_word_address (req_word_address),
      .req_write_data   (req_write_data),
      .program_length   (program_length_ff),
      .rsp_next_pc      (rsp_next_pc),
      .rsp_halted       (rsp_halted),
      .rsp_reg_written  (rsp_reg_written),
      .rsp_dest_reg     (rsp_dest_reg),
      .rsp_result_value (rsp_result_value),
      .rsp_mem_stored   (rsp_mem_stored),
      .rsp_mem_address  (rsp_mem_address),
      .rsp_branch_taken (rsp_branch_taken)
   );

endmodule

FILE: bench/risc_core_shared_memory_core_tb.sv
// Self-checking bench for the shared-memory core: drives command words, predicts
// every result word as requests are taken and compares it field by field.
// Depends on rcsm_pkg and the risc_core_shared_memory_core RTL only.
module risc_core_shared_memory_core_tb;

   localparam int MEM_WORDS       = 2048;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 16;
   localparam int PRESSURE_CYCLES = 150;
   localparam int PROGRAM_WORDS   = 21;
   localparam int unsigned PLEN_MAX = 2048;
   localparam logic [rcsm_pkg::CSR_ADDR_W-1:0] PLEN_ADDR =
      {rcsm_pkg::CSR_IDX_PROGRAM_LENGTH, 2'b00};
   localparam logic [rcsm_pkg::OPC_W-1:0] OP_NOP_FIRST = 4'd12;
   localparam logic [rcsm_pkg::OPC_W-1:0] OP_NOP_LAST  = 4'd15;

   typedef struct packed {
      logic [rcsm_pkg::ADDR_FIELD_W-1:0] next_pc;
      logic                              halted;
      logic                              reg_written;
      logic [rcsm_pkg::REG_IDX_W-1:0]    dest_reg;
      logic [rcsm_pkg::XLEN-1:0]         result_value;
      logic                              mem_stored;
      logic [rcsm_pkg::ADDR_FIELD_W-1:0] mem_address;
      logic                              branch_taken;
   } core_result_type;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic [1:0]                        req_command;
   logic [rcsm_pkg::ADDR_FIELD_W-1:0] req_word_address;
   logic [rcsm_pkg::XLEN-1:0]         req_write_data;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [rcsm_pkg::ADDR_FIELD_W-1:0] rsp_next_pc;
   logic                              rsp_halted;
   logic                              rsp_reg_written;
   logic [rcsm_pkg::REG_IDX_W-1:0]    rsp_dest_reg;
   logic [rcsm_pkg::XLEN-1:0]         rsp_result_value;
   logic                              rsp_mem_stored;
   logic [rcsm_pkg::ADDR_FIELD_W-1:0] rsp_mem_address;
   logic                              rsp_branch_taken;
   logic                              psel;
   logic                              penable;
   logic                              pwrite;
   logic [rcsm_pkg::CSR_ADDR_W-1:0]   paddr;
   logic [rcsm_pkg::CSR_DATA_W-1:0]   pwdata;
   logic [rcsm_pkg::CSR_DATA_W-1:0]   prdata;
   logic                              pready;

   // predicted core state
   logic [rcsm_pkg::XLEN-1:0]         model_mem [MEM_WORDS];
   logic                              model_written [MEM_WORDS];
   logic [rcsm_pkg::XLEN-1:0]         model_regs [rcsm_pkg::REG_COUNT];
   logic [rcsm_pkg::ADDR_FIELD_W-1:0] model_pc;
   logic [rcsm_pkg::PLEN_W-1:0]       model_plen;
   core_result_type                   pending_core_results[$];

   int fail_count;
   int send_gap_pct;
   int rsp_stall_pct;
   int hold_off_cycles;
   int idle_cycles = 0;

   risc_core_shared_memory_core #(
      .MEM_WORDS(MEM_WORDS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_word_address(req_word_address),
      .req_write_data  (req_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_next_pc     (rsp_next_pc),
      .rsp_halted      (rsp_halted),
      .rsp_reg_written (rsp_reg_written),
      .rsp_dest_reg    (rsp_dest_reg),
      .rsp_result_value(rsp_result_value),
      .rsp_mem_stored  (rsp_mem_stored),
      .rsp_mem_address (rsp_mem_address),
      .rsp_branch_taken(rsp_branch_taken),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #6 clock = ~clock;

   function automatic void check_field(string field, logic [rcsm_pkg::XLEN-1:0] want,
                                       logic [rcsm_pkg::XLEN-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
         fail_count++;
      end
   endfunction

   function automatic logic [rcsm_pkg::XLEN-1:0] encode_imm(logic [rcsm_pkg::OPC_W-1:0] opc,
                                                            int rs, int rt, int imm);
      return {opc, rcsm_pkg::REG_IDX_W'(rs), rcsm_pkg::REG_IDX_W'(rt),
              rcsm_pkg::IMM_W'(imm)};
   endfunction

   function automatic logic [rcsm_pkg::XLEN-1:0] encode_reg(logic [rcsm_pkg::OPC_W-1:0] opc,
                                                            int rs, int rt, int rd,
                                                            int shamt);
      return {opc, rcsm_pkg::REG_IDX_W'(rs), rcsm_pkg::REG_IDX_W'(rt),
              rcsm_pkg::REG_IDX_W'(rd), rcsm_pkg::SHAMT_W'(shamt)};
   endfunction

   // any opcode; small immediates half the time so shifts and offsets stay near
   function automatic logic [rcsm_pkg::XLEN-1:0] random_instruction();
      logic [rcsm_pkg::XLEN-1:0] ins;
      ins = $urandom;
      case ($urandom_range(3))
         0: begin
            ins[rcsm_pkg::IMM_W-1:0] = rcsm_pkg::IMM_W'($urandom_range(63));
         end
         1: begin
            ins[rcsm_pkg::IMM_W-1:0] = ~rcsm_pkg::IMM_W'($urandom_range(63));
         end
         default: ;
      endcase
      return ins;
   endfunction

   // advance the predicted core by one command word and return its result word
   function automatic core_result_type core_step_result(rcsm_pkg::cmd_code_type cmd,
         logic [rcsm_pkg::ADDR_FIELD_W-1:0] addr, logic [rcsm_pkg::XLEN-1:0] data);
      core_result_type                   res;
      logic [rcsm_pkg::XLEN-1:0]         ins;
      logic [rcsm_pkg::XLEN-1:0]         lhs;
      logic [rcsm_pkg::XLEN-1:0]         rhs;
      logic [rcsm_pkg::XLEN-1:0]         imm;
      logic [rcsm_pkg::XLEN-1:0]         value;
      logic [rcsm_pkg::OPC_W-1:0]        opc;
      logic [rcsm_pkg::REG_IDX_W-1:0]    dest;
      logic [rcsm_pkg::SHAMT_W-1:0]      shamt;
      logic [rcsm_pkg::ADDR_FIELD_W-1:0] npc;
      logic [rcsm_pkg::ADDR_FIELD_W-1:0] eff_addr;
      logic                              writes_reg;
      res = '0;
      case (cmd)
         rcsm_pkg::CMD_MEM_WRITE: begin
            model_mem[addr] = data;
            model_written[addr] = 1'b1;
            res.result_value = data;
            res.mem_address = addr;
         end
         rcsm_pkg::CMD_EXECUTE: begin
            if ({1'b0, model_pc} >= model_plen) begin
               res.halted = 1'b1;
            end else begin
               ins = model_mem[model_pc];
               opc = ins[rcsm_pkg::OPC_LSB +: rcsm_pkg::OPC_W];
               shamt = ins[rcsm_pkg::SHAMT_W-1:0];
               imm = {{(rcsm_pkg::XLEN-rcsm_pkg::IMM_W){ins[rcsm_pkg::IMM_W-1]}},
                      ins[rcsm_pkg::IMM_W-1:0]};
               lhs = model_regs[ins[rcsm_pkg::RS_LSB +: rcsm_pkg::REG_IDX_W]];
               rhs = model_regs[ins[rcsm_pkg::RT_LSB +: rcsm_pkg::REG_IDX_W]];
               dest = ins[rcsm_pkg::RT_LSB +: rcsm_pkg::REG_IDX_W];
               eff_addr = rcsm_pkg::ADDR_FIELD_W'(lhs + imm);
               npc = model_pc + 1'b1;
               value = '0;
               writes_reg = 1'b1;
               case (opc)
                  rcsm_pkg::OP_ADD: begin
                     value = lhs + rhs;
                     dest = ins[rcsm_pkg::RD_LSB +: rcsm_pkg::REG_IDX_W];
                  end
                  rcsm_pkg::OP_SUB: begin
                     value = lhs - rhs;
                     dest = ins[rcsm_pkg::RD_LSB +: rcsm_pkg::REG_IDX_W];
                  end
                  rcsm_pkg::OP_MULI: value = lhs * imm;
                  rcsm_pkg::OP_ADDI: value = lhs + imm;
                  rcsm_pkg::OP_ANDI: value = lhs & imm;
                  rcsm_pkg::OP_ORI:  value = lhs | imm;
                  rcsm_pkg::OP_SLL: begin
                     value = (shamt >= rcsm_pkg::SHAMT_W'(rcsm_pkg::XLEN)) ? '0 : lhs << shamt;
                  end
                  rcsm_pkg::OP_SRL: begin
                     value = (shamt >= rcsm_pkg::SHAMT_W'(rcsm_pkg::XLEN)) ? '0 : lhs >> shamt;
                  end
                  rcsm_pkg::OP_LW: begin
                     value = model_mem[eff_addr];
                     res.mem_address = eff_addr;
                  end
                  rcsm_pkg::OP_SW: begin
                     writes_reg = 1'b0;
                     model_mem[eff_addr] = rhs;
                     model_written[eff_addr] = 1'b1;
                     value = rhs;
                     res.mem_stored = 1'b1;
                     res.mem_address = eff_addr;
                  end
                  rcsm_pkg::OP_BNE: begin
                     writes_reg = 1'b0;
                     // target wraps modulo the memory size
                     if (lhs != rhs) begin
                        npc = model_pc + 1'b1 + imm[rcsm_pkg::ADDR_FIELD_W-1:0];
                        res.branch_taken = 1'b1;
                     end
                  end
                  rcsm_pkg::OP_J: begin
                     writes_reg = 1'b0;
                     npc = ins[rcsm_pkg::ADDR_FIELD_W-1:0];
                     res.branch_taken = 1'b1;
                  end
                  default: writes_reg = 1'b0;
               endcase
               // R0 stays zero but the value is still reported
               if (writes_reg) begin
                  res.dest_reg = dest;
                  if (dest != '0) begin
                     model_regs[dest] = value;
                     res.reg_written = 1'b1;
                  end
               end
               res.result_value = value;
               model_pc = npc;
            end
         end
         rcsm_pkg::CMD_REG_READ: begin
            res.result_value = model_regs[addr[rcsm_pkg::REG_IDX_W-1:0]];
         end
         default: begin
            res.result_value = model_mem[addr];
            res.mem_address = addr;
         end
      endcase
      res.next_pc = model_pc;
      return res;
   endfunction

   // called at a falling edge; returns at a falling edge with valid left high
   task automatic send_word(input rcsm_pkg::cmd_code_type cmd,
                            input logic [rcsm_pkg::ADDR_FIELD_W-1:0] addr,
                            input logic [rcsm_pkg::XLEN-1:0] data);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_word_address <= addr;
      req_write_data <= data;
      do @(posedge clock); while (req_stall);
      pending_core_results.push_back(core_step_result(cmd, addr, data));
      @(negedge clock);
   endtask

   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (pending_core_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // write program_length, then read it back
   task automatic write_program_length(input int unsigned length);
      wait_until_idle();
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= PLEN_ADDR;
      pwdata <= rcsm_pkg::CSR_DATA_W'(length);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      model_plen = rcsm_pkg::PLEN_W'(length);
      @(negedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      check_field("program_length", rcsm_pkg::XLEN'(model_plen), prdata);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // run one instruction; first load any word it would read that holds nothing yet
   task automatic execute_guarded();
      logic [rcsm_pkg::XLEN-1:0]         ins;
      logic [rcsm_pkg::XLEN-1:0]         imm;
      logic [rcsm_pkg::XLEN-1:0]         base;
      logic [rcsm_pkg::ADDR_FIELD_W-1:0] eff_addr;
      if ({1'b0, model_pc} < model_plen) begin
         if (!model_written[model_pc]) begin
            send_word(rcsm_pkg::CMD_MEM_WRITE, model_pc, random_instruction());
         end
         ins = model_mem[model_pc];
         imm = {{(rcsm_pkg::XLEN-rcsm_pkg::IMM_W){ins[rcsm_pkg::IMM_W-1]}},
                ins[rcsm_pkg::IMM_W-1:0]};
         base = model_regs[ins[rcsm_pkg::RS_LSB +: rcsm_pkg::REG_IDX_W]];
         eff_addr = rcsm_pkg::ADDR_FIELD_W'(base + imm);
         if (ins[rcsm_pkg::OPC_LSB +: rcsm_pkg::OPC_W] == rcsm_pkg::OP_LW &&
             !model_written[eff_addr]) begin
            send_word(rcsm_pkg::CMD_MEM_WRITE, eff_addr, $urandom);
         end
      end
      send_word(rcsm_pkg::CMD_EXECUTE, rcsm_pkg::ADDR_FIELD_W'($urandom), $urandom);
   endtask

   // read a random word, storing one there first when it holds nothing yet
   task automatic read_memory_guarded();
      logic [rcsm_pkg::ADDR_FIELD_W-1:0] addr;
      addr = rcsm_pkg::ADDR_FIELD_W'($urandom);
      if (!model_written[addr]) begin
         send_word(rcsm_pkg::CMD_MEM_WRITE, addr, $urandom);
      end
      send_word(rcsm_pkg::CMD_MEM_READ, addr, $urandom);
   endtask

   task automatic run_random_mix(input int unsigned count);
      int unsigned pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            // plant an instruction at pc, then run it
            send_word(rcsm_pkg::CMD_MEM_WRITE, model_pc, random_instruction());
            execute_guarded();
         end else if (pick < 60) begin
            execute_guarded();
         end else if (pick < 72) begin
            send_word(rcsm_pkg::CMD_MEM_WRITE, rcsm_pkg::ADDR_FIELD_W'($urandom),
                      $urandom_range(1) ? rcsm_pkg::XLEN'($urandom) : random_instruction());
         end else if (pick < 86) begin
            send_word(rcsm_pkg::CMD_REG_READ, rcsm_pkg::ADDR_FIELD_W'($urandom), $urandom);
         end else begin
            read_memory_guarded();
         end
      end
   endtask

   // load the directed program at the bottom of memory
   task automatic test_memory_load();
      logic [rcsm_pkg::XLEN-1:0] program_words [PROGRAM_WORDS];
      program_words[0]  = encode_imm(rcsm_pkg::OP_ADDI, 0, 1, -1);
      program_words[1]  = encode_imm(rcsm_pkg::OP_ADDI, 0, 2, rcsm_pkg::IMM_SPAN - 1);
      program_words[2]  = encode_reg(rcsm_pkg::OP_ADD, 1, 2, 3, 0);
      program_words[3]  = encode_reg(rcsm_pkg::OP_SUB, 0, 1, 4, 0);
      program_words[4]  = encode_imm(rcsm_pkg::OP_MULI, 2, 5, -rcsm_pkg::IMM_SPAN);
      program_words[5]  = encode_imm(rcsm_pkg::OP_ANDI, 1, 6, -rcsm_pkg::IMM_SPAN);
      program_words[6]  = encode_imm(rcsm_pkg::OP_ORI, 0, 7, 'h155);
      program_words[7]  = encode_reg(rcsm_pkg::OP_SLL, 1, 8, 0, 31);
      program_words[8]  = encode_reg(rcsm_pkg::OP_SRL, 1, 9, 0, 31);
      program_words[9]  = encode_reg(rcsm_pkg::OP_SLL, 1, 10, 0, 32);
      program_words[10] = encode_reg(rcsm_pkg::OP_SRL, 1, 11, 0, (1 << rcsm_pkg::SHAMT_W) - 1);
      program_words[11] = encode_imm(rcsm_pkg::OP_SW, 4, 1, 2000);
      // base of all ones wraps back onto the word just stored
      program_words[12] = encode_imm(rcsm_pkg::OP_LW, 1, 12, 2002);
      program_words[13] = encode_imm(rcsm_pkg::OP_ADDI, 1, 0, 5);
      program_words[14] = encode_imm(rcsm_pkg::OP_BNE, 0, 0, 5);
      program_words[15] = encode_imm(rcsm_pkg::OP_BNE, 1, 0, 1);
      program_words[16] = encode_reg(rcsm_pkg::OP_ADD, 1, 1, 13, 0);
      program_words[17] = {rcsm_pkg::OP_J, rcsm_pkg::JADDR_W'(28'h0FF_F812)};
      program_words[18] = {OP_NOP_FIRST, rcsm_pkg::JADDR_W'($urandom)};
      program_words[19] = {OP_NOP_LAST, rcsm_pkg::JADDR_W'($urandom)};
      // backward branch that wraps below zero
      program_words[20] = encode_imm(rcsm_pkg::OP_BNE, 1, 0, -100);
      send_gap_pct = 0;
      rsp_stall_pct = 0;
      for (int i = 0; i < PROGRAM_WORDS; i++) begin
         send_word(rcsm_pkg::CMD_MEM_WRITE, rcsm_pkg::ADDR_FIELD_W'(i), program_words[i]);
      end
   endtask

   task automatic test_halt_at_zero_length();
      send_word(rcsm_pkg::CMD_EXECUTE, '0, '0);
      write_program_length(0);
      send_word(rcsm_pkg::CMD_EXECUTE, '1, '1);
   endtask

   task automatic test_directed_program();
      write_program_length(PROGRAM_WORDS);
      // last one lands past program_length and halts
      repeat (PROGRAM_WORDS) begin
         send_word(rcsm_pkg::CMD_EXECUTE, rcsm_pkg::ADDR_FIELD_W'($urandom), $urandom);
      end
      send_word(rcsm_pkg::CMD_REG_READ, rcsm_pkg::ADDR_FIELD_W'(33), '0);
      send_word(rcsm_pkg::CMD_REG_READ, '1, '0);
      send_word(rcsm_pkg::CMD_MEM_READ, rcsm_pkg::ADDR_FIELD_W'(2001), '0);
      send_word(rcsm_pkg::CMD_MEM_WRITE, '1, '1);
      send_word(rcsm_pkg::CMD_MEM_READ, '1, '0);
   endtask

   task automatic test_steady_stream();
      write_program_length(PLEN_MAX);
      send_gap_pct = 0;
      rsp_stall_pct = 0;
      run_random_mix(50);
   endtask

   task automatic test_sender_gaps();
      write_program_length($urandom_range(PLEN_MAX - 1, 1));
      send_gap_pct = 45;
      rsp_stall_pct = 0;
      run_random_mix(50);
   endtask

   task automatic test_receiver_stalls();
      write_program_length(PLEN_MAX);
      send_gap_pct = 0;
      rsp_stall_pct = 45;
      run_random_mix(50);
   endtask

   task automatic test_backpressure();
      write_program_length(PLEN_MAX);
      send_gap_pct = 0;
      rsp_stall_pct = 0;
      hold_off_cycles = PRESSURE_CYCLES;
      run_random_mix(25);
   endtask

   task automatic test_mixed_idling();
      write_program_length($urandom_range(PLEN_MAX, 0));
      send_gap_pct = 13;
      rsp_stall_pct = 13;
      run_random_mix(50);
   endtask

   // receiver side: random stall, or a counted hold-off when one is requested
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : check_result_words
      core_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_core_results.size() == 0) begin
            $error("result word arrived with no prediction pending");
            fail_count++;
         end else begin
            want = pending_core_results.pop_front();
            check_field("next_pc", rcsm_pkg::XLEN'(want.next_pc),
                        rcsm_pkg::XLEN'(rsp_next_pc));
            check_field("halted", rcsm_pkg::XLEN'(want.halted),
                        rcsm_pkg::XLEN'(rsp_halted));
            check_field("reg_written", rcsm_pkg::XLEN'(want.reg_written),
                        rcsm_pkg::XLEN'(rsp_reg_written));
            check_field("dest_reg", rcsm_pkg::XLEN'(want.dest_reg),
                        rcsm_pkg::XLEN'(rsp_dest_reg));
            check_field("result_value", want.result_value, rsp_result_value);
            check_field("mem_stored", rcsm_pkg::XLEN'(want.mem_stored),
                        rcsm_pkg::XLEN'(rsp_mem_stored));
            check_field("mem_address", rcsm_pkg::XLEN'(want.mem_address),
                        rcsm_pkg::XLEN'(rsp_mem_address));
            check_field("branch_taken", rcsm_pkg::XLEN'(want.branch_taken),
                        rcsm_pkg::XLEN'(rsp_branch_taken));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = rcsm_pkg::CMD_MEM_WRITE;
      req_word_address = '0;
      req_write_data = '0;
      rsp_stall = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      fail_count = 0;
      send_gap_pct = 0;
      rsp_stall_pct = 0;
      hold_off_cycles = 0;
      model_pc = '0;
      model_plen = '0;
      foreach (model_regs[i]) model_regs[i] = '0;
      foreach (model_written[i]) model_written[i] = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_memory_load();
      test_halt_at_zero_length();
      test_directed_program();
      test_steady_stream();
      test_sender_gaps();
      test_receiver_stalls();
      test_backpressure();
      test_mixed_idling();
      wait_until_idle();
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
